>>> hdl/lzwd_pkg.sv
// Shared types and constants for the LZSS window decompressor.
`timescale 1ns / 1ps
package lzwd_pkg;

  localparam int WINDOW_DEPTH_DEF = 4096;
  localparam int LENGTH_BITS_DEF  = 24;

  // Header carries a 24-bit little-endian length after one type byte
  localparam int LEN_MAX_BITS = 24;
  localparam logic [2:0] HDR_BYTES = 3'd4;
  localparam logic [2:0] HDR_LEN_B0 = 3'd1;
  localparam logic [2:0] HDR_LEN_B1 = 3'd2;
  localparam logic [2:0] HDR_LEN_B2 = 3'd3;

  // Token format: high nibble is length minus 3, 12-bit distance minus 1
  localparam int DIST_BITS = 12;
  localparam int RUN_BITS  = 5;
  localparam logic [RUN_BITS-1:0] MATCH_MIN = 5'd3;

  // Flag index value that means the next byte is a flag byte
  localparam logic [3:0] FLAG_COUNT = 4'd8;

  typedef enum logic [1:0] {
    KIND_SILENT  = 2'd0,
    KIND_LITERAL = 2'd1,
    KIND_COPY    = 2'd2
  } kind_e;

  typedef struct packed {
    logic accept;
    logic rd;
    logic put;
    logic sel_copy;
  } lzwd_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  slot_free;
    logic  copy_last;
  } lzwd_sts_t;

endpackage

>>> hdl/lzwd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module lzwd_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/lzwd_ctrl.sv
// Controller state machine for the LZSS window decompressor.
`timescale 1ns / 1ps
module lzwd_ctrl import lzwd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lzwd_sts_t sts_i,
  output lzwd_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LIT  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_WR   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    in_ready_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          case (sts_i.kind)
            KIND_LITERAL: state_d = ST_LIT;
            KIND_COPY:    state_d = ST_RD;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_LIT: begin
        cmd_o.put = sts_i.slot_free;
        if (sts_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_WR;
      end
      ST_WR: begin
        cmd_o.sel_copy = 1'b1;
        cmd_o.put      = sts_i.slot_free;
        if (sts_i.slot_free) begin
          state_d = sts_i.copy_last ? ST_IDLE : ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/lzwd_dp.sv
// Datapath: stream parser, history window, copy counters and output register.
`timescale 1ns / 1ps
module lzwd_dp import lzwd_pkg::*; #(
  parameter int WindowDepth = WINDOW_DEPTH_DEF,
  parameter int LengthBits  = LENGTH_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [7:0] in_byte_i,
  input  logic      stream_start_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output logic [7:0] out_byte_o,
  output logic      run_last_o,
  output logic      stream_done_o,
  input  lzwd_cmd_t cmd_i,
  output lzwd_sts_t sts_o
);

  localparam int AddrW = $clog2(WindowDepth);

  logic [2:0]            hdr_q, hdr_d;
  logic [LengthBits-1:0] rem_q, rem_d;
  logic [AddrW-1:0]      wp_q, wp_d;
  logic [AddrW:0]        cnt_q, cnt_d;   // bytes written, saturating at the window depth
  logic [3:0]            idx_q, idx_d;
  logic [7:0]            flags_q, flags_d;
  logic [7:0]            tok_q, tok_d;
  logic                  pend_q, pend_d;
  logic [DIST_BITS-1:0]  dist_q, dist_d;
  logic [RUN_BITS-1:0]   len_q, len_d;
  logic [7:0]            byte_q, byte_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_byte_q, out_byte_d;
  logic                  run_last_q, run_last_d;
  logic                  done_q, done_d;

  logic [LEN_MAX_BITS-1:0] rem_ext;
  logic [LEN_MAX_BITS-1:0] rem_hdr;
  logic [7:0]              ram_rdata;
  logic [7:0]              put_val;
  logic [AddrW-1:0]        rd_addr;
  logic                    in_window;
  kind_e                   kind;

  assign rem_ext   = LEN_MAX_BITS'(rem_q);
  assign in_window = (AddrW + 1)'(dist_q) < cnt_q;
  assign rd_addr   = wp_q + AddrW'(~dist_q);
  assign put_val   = cmd_i.sel_copy ? (in_window ? ram_rdata : 8'h00) : byte_q;

  assign sts_o.kind      = kind;
  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.copy_last = (len_q == RUN_BITS'(1)) || (rem_q == LengthBits'(1));

  always_comb begin
    case (hdr_q)
      HDR_LEN_B0: rem_hdr = LEN_MAX_BITS'(in_byte_i);
      HDR_LEN_B1: rem_hdr = {8'h00, in_byte_i, rem_ext[7:0]};
      HDR_LEN_B2: rem_hdr = {in_byte_i, rem_ext[15:0]};
      default:    rem_hdr = rem_ext;
    endcase
  end

  always_comb begin
    hdr_d       = hdr_q;
    rem_d       = rem_q;
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    flags_d     = flags_q;
    tok_d       = tok_q;
    pend_d      = pend_q;
    dist_d      = dist_q;
    len_d       = len_q;
    byte_d      = byte_q;
    out_byte_d  = out_byte_q;
    run_last_d  = run_last_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind        = KIND_SILENT;

    if (cmd_i.accept) begin
      if (stream_start_i) begin
        // restart the parser; this byte is header byte 0
        hdr_d   = HDR_LEN_B0;
        rem_d   = '0;
        wp_d    = '0;
        cnt_d   = '0;
        idx_d   = FLAG_COUNT;
        flags_d = '0;
        pend_d  = 1'b0;
        tok_d   = '0;
      end else if (hdr_q != HDR_BYTES) begin
        hdr_d = hdr_q + 3'd1;
        rem_d = LengthBits'(rem_hdr);
      end else if (rem_q == '0) begin
        // stream complete: drop the byte
      end else if (idx_q[3]) begin
        flags_d = in_byte_i;
        idx_d   = '0;
      end else if (pend_q) begin
        pend_d  = 1'b0;
        idx_d   = idx_q + 4'd1;
        flags_d = {flags_q[6:0], 1'b0};
        dist_d  = {tok_q[3:0], in_byte_i};
        len_d   = RUN_BITS'(tok_q[7:4]) + MATCH_MIN;
        kind    = KIND_COPY;
      end else if (flags_q[7]) begin
        tok_d  = in_byte_i;
        pend_d = 1'b1;
      end else begin
        idx_d   = idx_q + 4'd1;
        flags_d = {flags_q[6:0], 1'b0};
        byte_d  = in_byte_i;
        kind    = KIND_LITERAL;
      end
    end

    if (cmd_i.put) begin
      wp_d        = wp_q + AddrW'(1);
      cnt_d       = cnt_q[AddrW] ? cnt_q : cnt_q + (AddrW + 1)'(1);
      rem_d       = rem_q - LengthBits'(1);
      len_d       = len_q - RUN_BITS'(1);
      out_valid_d = 1'b1;
      out_byte_d  = put_val;
      run_last_d  = cmd_i.sel_copy ? sts_o.copy_last : 1'b1;
      done_d      = (rem_q == LengthBits'(1));
    end
  end

  lzwd_ram #(
    .Width(8),
    .Depth(WindowDepth)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (cmd_i.put),
    .waddr_i(wp_q),
    .wdata_i(put_val),
    .re_i   (cmd_i.rd),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q       <= '0;
      rem_q       <= '0;
      wp_q        <= '0;
      cnt_q       <= '0;
      idx_q       <= FLAG_COUNT;
      flags_q     <= '0;
      tok_q       <= '0;
      pend_q      <= 1'b0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hdr_q       <= hdr_d;
      rem_q       <= rem_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      flags_q     <= flags_d;
      tok_q       <= tok_d;
      pend_q      <= pend_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q     <= dist_d;
    byte_q     <= byte_d;
    out_byte_q <= out_byte_d;
    run_last_q <= run_last_d;
    done_q     <= done_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign run_last_o    = run_last_q;
  assign stream_done_o = done_q;

  // A result is only loaded when the output register is free or draining
  a_put_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending result");

  // A window read is only issued with copy bytes left and length remaining
  a_rd_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> (len_q != '0 && rem_q != '0))
    else $error("window read with nothing left to copy");

  // The byte that carries stream_done leaves the remaining length at zero
  a_done_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.put && rem_q == LengthBits'(1)) |=> (rem_q == '0 && done_q && run_last_q))
    else $error("stream end not flagged on the final byte");

endmodule

>>> hdl/lz77_window_decompressor_unit.sv
// Top level of the LZSS decompressor with a 4096-byte history window.
// Header, flag and first token bytes give no result; a literal is registered
//   and then loaded into the output register once that register is free.
// Each copied byte is a registered window read and then a write; a new input
//   byte is taken only after the literal or copy before it is through.
// Reset: rst_ni clears the parser, counters and output valid; the window RAM
//   is not cleared, since reads reaching before the first byte give zero.
`timescale 1ns / 1ps
module lz77_window_decompressor_unit import lzwd_pkg::*; #(
  parameter int WindowDepth = WINDOW_DEPTH_DEF,
  parameter int LengthBits  = LENGTH_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // compressed stream, one byte per transfer
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       stream_start_i,
  // decompressed bytes, one per transfer
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       stream_done_o
);

  lzwd_cmd_t cmd;
  lzwd_sts_t sts;

  // Controller: takes a byte only when idle, then walks literal or copy steps.
  lzwd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Datapath: parses header, flags and tokens; holds the window and the
  // output register, which lets a new byte transfer in while a result waits.
  lzwd_dp #(
    .WindowDepth(WindowDepth),
    .LengthBits (LengthBits)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_byte_i     (in_byte_i),
    .stream_start_i(stream_start_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

>>> dv/lzwd_byte_checker.sv
// Scoreboard that predicts the decompressed byte stream and checks every output transfer.
`timescale 1ns / 1ps
module lzwd_byte_checker import lzwd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       stream_start_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       run_last_i,
  input  logic       stream_done_i,
  output int         fail_count_o,
  output int         bytes_owed_o
);

  localparam int ReportCap = 20;
  localparam logic [LEN_MAX_BITS-1:0] LenMask = LEN_MAX_BITS'((1 << LENGTH_BITS_DEF) - 1);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       done;
  } out_beat_t;

  out_beat_t               owed_q[$];
  logic [7:0]              window_mem [WINDOW_DEPTH_DEF];
  logic [DIST_BITS-1:0]    wr_pos;
  logic [LEN_MAX_BITS-1:0] written;
  logic [LEN_MAX_BITS-1:0] remaining;
  logic [2:0]              hdr_idx;
  logic [7:0]              flag_bits;
  logic [3:0]              flag_idx;
  logic [7:0]              tok_high;
  logic                    tok_pending;
  int                      out_count;

  // Append one decoded byte to the window and to the owed results.
  task automatic emit_byte(input logic [7:0] value);
    window_mem[wr_pos] = value;
    wr_pos++;
    written++;
    remaining--;
    owed_q.push_back('{data: value, run_last: 1'b0, done: (remaining == '0)});
  endtask

  // Advance the parser by one compressed byte and queue the bytes it yields.
  task automatic decode_byte(input logic [7:0] b, input logic start);
    int                   first_new;
    int                   run_len;
    logic [DIST_BITS:0]   back_dist;
    logic [DIST_BITS-1:0] rd_addr;
    logic [7:0]           value;
    out_beat_t            last_beat;
    first_new = owed_q.size();
    if (start) begin
      hdr_idx     = '0;
      written     = '0;
      remaining   = '0;
      wr_pos      = '0;
      flag_idx    = FLAG_COUNT;
      flag_bits   = '0;
      tok_pending = 1'b0;
      tok_high    = '0;
    end
    if (hdr_idx < HDR_BYTES) begin
      case (hdr_idx)
        HDR_LEN_B0: remaining = {16'd0, b};
        HDR_LEN_B1: remaining[15:8] = b;
        HDR_LEN_B2: begin
          remaining[23:16] = b;
          remaining = remaining & LenMask;
        end
        default: ;
      endcase
      hdr_idx++;
      return;
    end
    // stream complete or empty: drop everything until the next restart
    if (remaining == '0) return;
    if (flag_idx >= FLAG_COUNT) begin
      flag_bits = b;
      flag_idx  = '0;
      return;
    end
    if (tok_pending) begin
      back_dist   = {1'b0, tok_high[3:0], b} + 1'b1;
      run_len     = int'(tok_high[7:4]) + int'(MATCH_MIN);
      tok_pending = 1'b0;
      flag_idx++;
      // overlapping copies read bytes written earlier in this same run
      while (run_len > 0 && remaining != '0) begin
        value = '0;
        if (back_dist <= written) begin
          rd_addr = wr_pos - back_dist[DIST_BITS-1:0];
          value   = window_mem[rd_addr];
        end
        emit_byte(value);
        run_len--;
      end
    end else if (flag_bits[7 - flag_idx]) begin
      tok_high    = b;
      tok_pending = 1'b1;
      return;
    end else begin
      flag_idx++;
      emit_byte(b);
    end
    if (owed_q.size() > first_new) begin
      last_beat = owed_q.pop_back();
      last_beat.run_last = 1'b1;
      owed_q.push_back(last_beat);
    end
  endtask

  task automatic report_mismatch(input string what);
    fail_count_o++;
    if (fail_count_o <= ReportCap) begin
      $display("checker: output byte %0d: %s", out_count, what);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      owed_q.delete();
      wr_pos       = '0;
      written      = '0;
      remaining    = '0;
      hdr_idx      = '0;
      flag_bits    = '0;
      flag_idx     = FLAG_COUNT;
      tok_high     = '0;
      tok_pending  = 1'b0;
      out_count    = 0;
      fail_count_o = 0;
      bytes_owed_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        decode_byte(in_byte_i, stream_start_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (owed_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", out_byte_i));
        end else begin
          want = owed_q.pop_front();
          if (out_byte_i !== want.data) begin
            report_mismatch($sformatf("data %02h, want %02h", out_byte_i, want.data));
          end
          if (run_last_i !== want.run_last) begin
            report_mismatch($sformatf("run_last %b, want %b", run_last_i, want.run_last));
          end
          if (stream_done_i !== want.done) begin
            report_mismatch($sformatf("stream_done %b, want %b", stream_done_i, want.done));
          end
        end
        out_count++;
      end
      bytes_owed_o = owed_q.size();
    end
  end

endmodule

>>> dv/tb_lz77_window_decompressor_unit.sv
// Testbench top: feeds compressed streams to the decompressor and reports the verdict.
`timescale 1ns / 1ps
module tb_lz77_window_decompressor_unit;
  import lzwd_pkg::*;

  // Longest quiet stretch of a healthy run: a sender gap plus a receiver
  // stall plus the window RAM steps. The limit sits far above that.
  localparam int IdleLimit    = 2000;
  // Drain long enough for a full 18-byte copy to come out
  localparam int DrainCycles  = 40;
  // Counted items ahead of the long stream, directed ones included
  localparam int RandomTarget = 40;
  // One stream longer than the window, so the write pointer wraps
  localparam int LongStreamLen = 4100;
  localparam int NoCap         = 1000000;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } in_beat_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_STALLS,
    READY_THIRDS
  } ready_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       stream_start_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic       stream_done_o;

  int          fail_count;
  int          bytes_owed;
  in_beat_t    stim_q[$];
  int          counted_items;
  int          idle_cycles;
  int          stall_left;
  int          mode_age;
  ready_mode_e ready_mode = READY_ALWAYS;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  lz77_window_decompressor_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .stream_start_i(stream_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o)
  );

  lzwd_byte_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .stream_start_i(stream_start_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_i    (out_byte_o),
    .run_last_i    (run_last_o),
    .stream_done_i (stream_done_o),
    .fail_count_o  (fail_count),
    .bytes_owed_o  (bytes_owed)
  );

  // Queue one compressed byte; bytes the block merely drops are not counted.
  task automatic push_item(input logic [7:0] data, input logic start, input bit counts);
    stim_q.push_back('{data: data, start: start});
    if (counts) counted_items++;
  endtask

  // Encode one stream: header, then flag groups with random literals and tokens.
  // The item cap cuts the stream short anywhere, even inside a header or a token,
  // so the next restart lands on a half-parsed stream.
  task automatic build_stream(input int out_len, input int item_cap, input bit long_runs);
    int          produced;
    int          items;
    int          run_len;
    int          span;
    logic [23:0] len_field;
    logic [7:0]  flags;
    logic [11:0] back_m1;
    logic [3:0]  run_nib;
    len_field = out_len[23:0];
    produced  = 0;
    push_item(8'($urandom), 1'b1, 1'b1);
    items = 1;
    for (int k = 0; k < 3 && items < item_cap; k++) begin
      push_item(len_field[8*k +: 8], 1'b0, 1'b1);
      items++;
    end
    while (produced < out_len && items < item_cap) begin
      if (long_runs && $urandom_range(0, 7) != 0) flags = 8'hff;
      else flags = 8'($urandom);
      push_item(flags, 1'b0, 1'b1);
      items++;
      for (int k = 7; k >= 0 && produced < out_len && items < item_cap; k--) begin
        if (flags[k]) begin
          if (long_runs) run_nib = 4'hf;
          else run_nib = 4'($urandom);
          // mostly reach back into this stream, short distances for overlap,
          // now and then anywhere in the 12-bit range
          span = (produced > WINDOW_DEPTH_DEF) ? WINDOW_DEPTH_DEF : produced;
          if (produced == 0 || $urandom_range(0, 7) == 0) begin
            back_m1 = 12'($urandom);
          end else if ($urandom_range(0, 1) == 0) begin
            back_m1 = 12'($urandom_range(0, (span > 8) ? 7 : span - 1));
          end else begin
            back_m1 = 12'($urandom_range(0, span - 1));
          end
          push_item({run_nib, back_m1[11:8]}, 1'b0, 1'b1);
          items++;
          if (items < item_cap) begin
            push_item(back_m1[7:0], 1'b0, 1'b1);
            items++;
            run_len = int'(run_nib) + int'(MATCH_MIN);
            produced += (run_len > out_len - produced) ? out_len - produced : run_len;
          end
        end else begin
          push_item(8'($urandom), 1'b0, 1'b1);
          items++;
          produced++;
        end
      end
    end
  endtask

  // Receiver: switch between ready patterns at random intervals.
  always @(posedge clk_i) begin
    if (mode_age == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      mode_age   <= $urandom_range(16, 80);
    end else begin
      mode_age <= mode_age - 1;
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      case (ready_mode)
        READY_ALWAYS: out_ready_i <= 1'b1;
        READY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        READY_STALLS: begin
          if ($urandom_range(0, 7) == 0) begin
            out_ready_i <= 1'b0;
            stall_left  <= $urandom_range(1, 20);
          end else begin
            out_ready_i <= 1'b1;
          end
        end
        default: out_ready_i <= (mode_age % 3 == 0);
      endcase
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Hold valid and payload until the transfer, then return at that edge.
  task automatic send_item(input in_beat_t beat);
    in_valid_i     <= 1'b1;
    in_byte_i      <= beat.data;
    stream_start_i <= beat.start;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    int pick;
    int idx;
    int burst;
    int gap;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_byte_i      = '0;
    stream_start_i = 1'b0;
    out_ready_i    = 1'b0;
    idle_cycles    = 0;
    counted_items  = 0;

    // First stream, no start flag: after reset the first byte is still the type
    // byte. Length 18. Flags 0x30: two literals, a token reaching before the
    // first byte (yields zeros), then an overlapping 18-byte copy at distance 5
    // that is cut at the declared length. Two trailing bytes are dropped.
    push_item(8'ha5, 1'b0, 1'b1);
    push_item(8'h12, 1'b0, 1'b1);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h30, 1'b0, 1'b1);
    push_item(8'h5a, 1'b0, 1'b1);
    push_item(8'hff, 1'b0, 1'b1);
    push_item(8'h0f, 1'b0, 1'b1);
    push_item(8'hff, 1'b0, 1'b1);
    push_item(8'hf0, 1'b0, 1'b1);
    push_item(8'h04, 1'b0, 1'b1);
    push_item(8'h12, 1'b0, 1'b0);
    push_item(8'h34, 1'b0, 1'b0);
    // Zero length: complete right after the header, the next byte is dropped
    push_item(8'h3c, 1'b1, 1'b1);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h55, 1'b0, 1'b0);
    // Largest length, one literal, then a restart in the middle of the stream
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hff, 1'b0, 1'b1);
    push_item(8'hff, 1'b0, 1'b1);
    push_item(8'hff, 1'b0, 1'b1);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h80, 1'b0, 1'b1);

    // Random part: mostly complete streams, some noise and cut streams
    while (counted_items < RandomTarget) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        build_stream($urandom_range(0, 24'hffffff), $urandom_range(1, 10), 1'b0);
      end else if (pick == 1) begin
        build_stream($urandom_range(1, 60), $urandom_range(2, 20), 1'b0);
      end else begin
        if ($urandom_range(0, 7) == 0) build_stream($urandom_range(60, 200), NoCap, 1'b0);
        else build_stream($urandom_range(0, 40), NoCap, 1'b0);
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) push_item(8'($urandom), 1'b0, 1'b0);
        end
      end
    end
    build_stream(LongStreamLen, NoCap, 1'b1);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender: bursts of random length, random gaps, now and then a long burst
    idx = 0;
    while (idx < stim_q.size()) begin
      burst = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 12);
      for (int k = 0; k < burst && idx < stim_q.size(); k++) begin
        send_item(stim_q[idx]);
        idx++;
      end
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
      if (gap > 0 && idx < stim_q.size()) begin
        in_valid_i     <= 1'b0;
        in_byte_i      <= 8'($urandom);
        stream_start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    // Wait for every owed byte, then drain to catch stray extra output
    do @(negedge clk_i); while (bytes_owed != 0);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && bytes_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
